// ===== src/wsd_pkg.sv =====
// ============================================================================
// wsd_pkg: shared types and constants for the WebSocket frame deframer
// Item structs for both channels and the header field constants.
// ============================================================================
package wsd_pkg;

  // Input item: one received stream byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
  } wsd_in_t;

  // Result item: one payload byte, an empty-frame end or an error report.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] frame_opcode;
    logic       frame_end;
    logic       oversize_error;
  } wsd_out_t;

  localparam logic [31:0] MaxPayloadReset = 32'd10485760;  // 10 MiB
  localparam logic [6:0]  LenCode16       = 7'd126;
  localparam logic [6:0]  LenCode64       = 7'd127;
  localparam logic [2:0]  Ext16Bytes      = 3'd1;  // remaining bytes minus one
  localparam logic [2:0]  Ext64Bytes      = 3'd7;
  localparam logic [2:0]  KeyBytes        = 3'd3;

endpackage

// ===== src/wsd_parser.sv =====
// ============================================================================
// wsd_parser: frame header parser and payload unmasker
// Holds the parse state and forms at most one result for each accepted byte.
// ============================================================================
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  wsd_in_t     item,
  input  logic [31:0] max_payload_bytes,
  output logic        res_valid,
  output wsd_out_t    res
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask, mask_next;
  logic [63:0] frame_len, frame_len_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic [31:0] key, key_next;
  logic [1:0]  pos, pos_next;
  logic [31:0] remain, remain_next;
  logic        stopped, stopped_next;

  phase_t      cur_phase;
  logic        cur_stopped;
  logic [7:0]  b;
  logic [7:0]  key_byte;
  logic        do_after;
  logic        do_finish;
  logic [63:0] len_now;

  assign b           = item.data_byte;
  // A new connection restarts parsing with this byte as the first header byte.
  assign cur_phase   = item.new_connection ? PH_HDR0 : phase;
  assign cur_stopped = item.new_connection ? 1'b0 : stopped;

  always_comb begin
    case (pos)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  always_comb begin
    phase_next     = phase;
    opcode_next    = opcode;
    mask_next      = mask;
    frame_len_next = frame_len;
    hdr_cnt_next   = hdr_cnt;
    key_next       = key;
    pos_next       = pos;
    remain_next    = remain;
    stopped_next   = cur_stopped;
    do_after       = 1'b0;
    do_finish      = 1'b0;
    len_now        = frame_len;
    res_valid      = 1'b0;
    res            = '0;
    res.frame_opcode = opcode;

    if (accept && !cur_stopped) begin
      case (cur_phase)
        PH_HDR1: begin
          mask_next = b[7];
          if (b[6:0] == LenCode16) begin
            phase_next     = PH_EXT;
            hdr_cnt_next   = Ext16Bytes;
            frame_len_next = '0;
          end else if (b[6:0] == LenCode64) begin
            phase_next     = PH_EXT;
            hdr_cnt_next   = Ext64Bytes;
            frame_len_next = '0;
          end else begin
            len_now        = {57'd0, b[6:0]};
            frame_len_next = len_now;
            do_after       = 1'b1;
          end
        end
        PH_EXT: begin
          len_now        = {frame_len[55:0], b};
          frame_len_next = len_now;
          if (hdr_cnt != 3'd0) begin
            hdr_cnt_next = hdr_cnt - 3'd1;
          end else begin
            do_after = 1'b1;
          end
        end
        PH_KEY: begin
          key_next = {key[23:0], b};
          if (hdr_cnt != 3'd0) begin
            hdr_cnt_next = hdr_cnt - 3'd1;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_DATA: begin
          res_valid        = 1'b1;
          res.payload_byte = mask ? (b ^ key_byte) : b;
          res.has_byte     = 1'b1;
          res.frame_end    = (remain == 32'd1);
          pos_next         = pos + 2'd1;
          remain_next      = remain - 32'd1;
          if (remain == 32'd1) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          opcode_next = b[3:0];
          phase_next  = PH_HDR1;
        end
      endcase

      // Length is known: a masked frame still has its key to collect.
      if (do_after) begin
        if (mask_next) begin
          phase_next   = PH_KEY;
          hdr_cnt_next = KeyBytes;
          key_next     = '0;
        end else begin
          do_finish = 1'b1;
        end
      end

      // Header complete: check the length against the limit.
      if (do_finish) begin
        pos_next = 2'd0;
        if ((len_now[63:32] != 32'd0) || (len_now[31:0] > max_payload_bytes)) begin
          stopped_next       = 1'b1;
          res_valid          = 1'b1;
          res.oversize_error = 1'b1;
        end else if (len_now == 64'd0) begin
          phase_next    = PH_HDR0;
          res_valid     = 1'b1;
          res.frame_end = 1'b1;
        end else begin
          phase_next  = PH_DATA;
          remain_next = len_now[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR0;
      stopped <= 1'b0;
      hdr_cnt <= '0;
      pos     <= '0;
      remain  <= '0;
      opcode  <= '0;
      mask    <= 1'b0;
    end else if (accept) begin
      phase   <= phase_next;
      stopped <= stopped_next;
      hdr_cnt <= hdr_cnt_next;
      pos     <= pos_next;
      remain  <= remain_next;
      opcode  <= opcode_next;
      mask    <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_len <= frame_len_next;
      key       <= key_next;
    end
  end

endmodule

// ===== src/wsd_out_buf.sv =====
// ============================================================================
// wsd_out_buf: two-entry result buffer
// Registers results and decouples the input stall from the output stall.
// ============================================================================
module wsd_out_buf import wsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  wsd_out_t push_item,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output wsd_out_t out_item
);

  wsd_out_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== src/websocket_frame_deframer.sv =====
// ============================================================================
// websocket_frame_deframer: WebSocket receive frame parser
// Parses frame headers from a byte stream and gives out unmasked payload
// bytes with their opcode, frame end marks and an oversize error report.
// ============================================================================
//
//  Channel  Direction  Handshake              Item
//  -------  ---------  ---------------------  ---------------------------------
//  in       input      in_valid / in_stall    wsd_in_t: stream byte, new conn
//  out      output     out_valid / out_stall  wsd_out_t: payload byte + flags
//  cfg      input      cfg_wr_en              max_payload_bytes (32 bit)
//
// The block accepts one byte every cycle while in_stall is low; a result, if
// the byte causes one, is registered in the result buffer behind any older ones.
// The parser updates its state on each accepted byte, and the two-entry
// result buffer keeps full rate while the output is not stalled.
// in_stall rises only when both buffer entries hold undelivered results.
// Reset (rst, synchronous) returns the parser to the first header byte and
// loads max_payload_bytes with 10485760.
//
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  wsd_in_t     in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output wsd_out_t    out_item,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic        accept;
  logic        res_valid;
  wsd_out_t    res;
  logic        buf_full;
  logic [31:0] max_payload_bytes;

  // The parser only advances on an accepted byte. The stall comes straight
  // from the buffer's fill count, so there is no path from out_stall to it.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // Length limit register; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes <= MaxPayloadReset;
    end else if (cfg_wr_en) begin
      max_payload_bytes <= cfg_wr_data;
    end
  end

  wsd_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .item              (in_item),
    .max_payload_bytes (max_payload_bytes),
    .res_valid         (res_valid),
    .res               (res)
  );

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_item (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top: self-checking testbench for websocket_frame_deframer
// Feeds frame headers, masking keys and payload bytes through the input
// channel. A behavioral frame parser in the bench predicts every result, and
// the results are checked in order while both channels idle at random.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
  import wsd_pkg::*;

  // How the length of a generated frame is coded in its second header byte.
  localparam int FormShort = 0;  // 7-bit length code
  localparam int Form16    = 1;  // code 126 and a 16-bit length
  localparam int Form64    = 2;  // code 127 and a 64-bit length

  // Cycles allowed for the block to settle once nothing more is expected.
  localparam int SettleCycles = 4;

  typedef enum logic [2:0] {
    AT_HDR0,
    AT_HDR1,
    AT_EXT_LEN,
    AT_KEY,
    AT_PAYLOAD
  } parse_phase_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  wsd_in_t     in_item;
  logic        out_valid;
  logic        out_stall;
  wsd_out_t    out_item;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  websocket_frame_deframer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Parser state as the bench believes it to be after every accepted byte.
  parse_phase_t phase;
  logic [3:0]   opcode;
  logic         masked;
  logic [63:0]  frame_len;
  logic [2:0]   hdr_left;
  logic [31:0]  mask_key;
  logic [63:0]  payload_pos;
  logic         halted;
  logic [31:0]  payload_limit;

  // Results that the parser owes, oldest first.
  wsd_out_t expected_results[$];

  int   parsed_bytes;     // accepted bytes that the parser did not ignore
  int   mismatch_count;
  logic calm;             // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Frame parser prediction
  // --------------------------------------------------------------------------

  function automatic wsd_out_t make_result(input logic [7:0] data, input logic has,
                                           input logic last, input logic err);
    wsd_out_t r;
    r.payload_byte   = data;
    r.has_byte       = has;
    r.frame_opcode   = opcode;
    r.frame_end      = last;
    r.oversize_error = err;
    return r;
  endfunction

  task automatic clear_parse_state();
    phase       = AT_HDR0;
    opcode      = '0;
    masked      = 1'b0;
    frame_len   = '0;
    hdr_left    = '0;
    mask_key    = '0;
    payload_pos = '0;
    halted      = 1'b0;
  endtask

  // The header is complete: the length check happens only here, after any
  // masking key, so a masked oversize frame reports on its last key byte.
  task automatic close_header();
    payload_pos = '0;
    if (frame_len > {32'd0, payload_limit}) begin
      halted = 1'b1;
      expected_results.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1));
    end else if (frame_len == 64'd0) begin
      phase = AT_HDR0;
      expected_results.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b0));
    end else begin
      phase = AT_PAYLOAD;
    end
  endtask

  // The length is known: a masked frame still has its key to come.
  task automatic length_known();
    if (masked) begin
      phase    = AT_KEY;
      hdr_left = KeyBytes;
      mask_key = '0;
    end else begin
      close_header();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic nc);
    logic [6:0] code;
    logic [7:0] data;
    logic       last;
    if (nc) clear_parse_state();
    // After an oversize report every byte is dropped until a new connection.
    if (halted) return;
    parsed_bytes++;
    case (phase)
      AT_HDR1: begin
        masked    = b[7];
        code      = b[6:0];
        frame_len = '0;
        if (code == LenCode16) begin
          phase    = AT_EXT_LEN;
          hdr_left = Ext16Bytes;
        end else if (code == LenCode64) begin
          phase    = AT_EXT_LEN;
          hdr_left = Ext64Bytes;
        end else begin
          frame_len = {57'd0, code};
          length_known();
        end
      end
      AT_EXT_LEN: begin
        frame_len = {frame_len[55:0], b};
        if (hdr_left != 0) hdr_left--;
        else length_known();
      end
      AT_KEY: begin
        mask_key = {mask_key[23:0], b};
        if (hdr_left != 0) hdr_left--;
        else close_header();
      end
      AT_PAYLOAD: begin
        // Key bytes are applied in stream order, first key byte first.
        data = masked ? (b ^ mask_key[8 * (3 - payload_pos[1:0]) +: 8]) : b;
        payload_pos++;
        last = (payload_pos >= frame_len);
        if (last) phase = AT_HDR0;
        expected_results.push_back(make_result(data, 1'b1, last, 1'b0));
      end
      default: begin
        // First header byte: FIN and the reserved bits are not used.
        opcode = b[3:0];
        phase  = AT_HDR1;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  wsd_out_t want;

  // Outputs are sampled at the rising edge, before the block updates them.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(out_item), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", 64'(out_item.payload_byte),
                          64'(want.payload_byte));
        if (out_item.has_byte !== want.has_byte)
          report_mismatch("has_byte", 64'(out_item.has_byte), 64'(want.has_byte));
        if (out_item.frame_opcode !== want.frame_opcode)
          report_mismatch("frame_opcode", 64'(out_item.frame_opcode),
                          64'(want.frame_opcode));
        if (out_item.frame_end !== want.frame_end)
          report_mismatch("frame_end", 64'(out_item.frame_end), 64'(want.frame_end));
        if (out_item.oversize_error !== want.oversize_error)
          report_mismatch("oversize_error", 64'(out_item.oversize_error),
                          64'(want.oversize_error));
      end
    end
  end

  // The receiver stalls in random bursts, except in the calm part at the end
  // of the run.
  initial begin : out_pacing
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && !calm && $urandom_range(0, 5) == 0) hold = int'($urandom_range(1, 7));
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; each is entered and left just after a falling edge.
  // --------------------------------------------------------------------------

  // Sends one stream byte, with an optional random gap in front of it. The
  // byte is taken at the first rising edge where in_stall is low, and the
  // prediction is updated at that edge.
  task automatic put_byte(input logic [7:0] b, input logic nc);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_item  <= {b, nc};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    parse_byte(b, nc);
    @(negedge clk);
  endtask

  // Holds the sender until every owed result has come out, then lets the
  // block settle, since header bytes may still be in flight without a result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Only called while the block is idle.
  task automatic set_limit(input logic [31:0] limit);
    cfg_wr_data <= limit;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    payload_limit = limit;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends one frame: header, extended length, key when masked, and up to
  // keep payload bytes with random content. A frame cut short leaves the
  // parser mid-frame for the next one to resync with a new connection.
  task automatic send_frame(input logic [7:0] first, input logic mask, input logic [63:0] len,
                            input int form, input longint keep, input logic nc);
    logic [31:0] key;
    logic [6:0]  code;
    longint      n;
    key = $urandom;
    if (form == Form16) code = LenCode16;
    else if (form == Form64) code = LenCode64;
    else code = len[6:0];
    put_byte(first, nc);
    put_byte({mask, code}, 1'b0);
    if (form == Form16) begin
      put_byte(len[15:8], 1'b0);
      put_byte(len[7:0], 1'b0);
    end else if (form == Form64) begin
      for (int i = 7; i >= 0; i--) put_byte(len[8 * i +: 8], 1'b0);
    end
    if (mask) for (int i = 3; i >= 0; i--) put_byte(key[8 * i +: 8], 1'b0);
    n = (len > 64'(keep)) ? keep : longint'(len);
    for (longint i = 0; i < n; i++) put_byte(8'($urandom), 1'b0);
  endtask

  // One random frame, mostly well formed. A new connection is forced when
  // the parser is stopped or mid-frame, and otherwise happens now and then.
  task automatic random_frame();
    logic [7:0]  first;
    logic        mask;
    logic [63:0] len;
    logic        nc;
    int          form;
    int          pick;
    longint      keep;
    first = 8'($urandom);
    mask  = 1'($urandom);
    pick  = int'($urandom_range(0, 99));
    nc    = (halted || phase != AT_HDR0) ? 1'b1 : ($urandom_range(0, 19) == 0);
    if (pick >= 95) begin
      // Noise: loose bytes, some of them opening a new connection.
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    if (pick < 70) begin
      form = FormShort;
      len  = ($urandom_range(0, 19) == 0) ? 64'($urandom_range(0, 125))
                                          : 64'($urandom_range(0, 12));
    end else if (pick < 85) begin
      form = Form16;
      len  = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 65535))
                                         : 64'($urandom_range(0, 24));
    end else begin
      form = Form64;
      len  = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 24));
    end
    keep = (len > 64'd130) ? 40 : longint'(len);
    if (len > {32'd0, payload_limit}) keep = (keep > 3) ? 3 : keep;
    if ($urandom_range(0, 9) == 0) keep = longint'($urandom_range(0, int'(keep)));
    send_frame(first, mask, len, form, keep, nc);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Short and extended frames at the reset limit: an empty frame, a masked
  // one-byte frame, a 16-bit length, a 64-bit length with the reserved top
  // bit set (always oversize), bytes ignored after the error, a new
  // connection, a frame cut off mid-payload, and a masked empty frame.
  task automatic test_frame_headers();
    send_frame(8'h8F, 1'b0, 64'd0, FormShort, 0, 1'b0);
    send_frame(8'h00, 1'b1, 64'd1, FormShort, 1, 1'b0);
    send_frame(8'hF2, 1'b0, 64'd1, Form16, 1, 1'b0);
    send_frame(8'h71, 1'b0, 64'h8000_0000_0000_0000, Form64, 1, 1'b0);
    send_frame(8'h88, 1'b0, 64'd3, FormShort, 1, 1'b1);
    send_frame(8'h8A, 1'b1, 64'd0, FormShort, 0, 1'b1);
  endtask

  // The limit at its extremes and at an exact boundary, each with a frame
  // just inside it and one just beyond. A masked frame over the limit must
  // report only after its key.
  task automatic test_length_limit();
    wait_idle();
    set_limit(32'd0);
    send_frame(8'h81, 1'b0, 64'd0, FormShort, 0, 1'b1);
    send_frame(8'h82, 1'b1, 64'd1, FormShort, 1, 1'b0);
    wait_idle();
    set_limit(32'hFFFF_FFFF);
    send_frame(8'h02, 1'b0, 64'hFFFF_FFFF, Form64, 3, 1'b1);
    send_frame(8'h03, 1'b1, 64'h1_0000_0000, Form64, 0, 1'b1);
    send_frame(8'h81, 1'b1, 64'hFFFF, Form16, 2, 1'b1);
    wait_idle();
    set_limit(32'd20);
    send_frame(8'h81, 1'b1, 64'd20, Form16, 20, 1'b1);
    send_frame(8'h81, 1'b0, 64'd21, FormShort, 0, 1'b0);
  endtask

  // Random frames under one limit until count bytes have been parsed. Now
  // and then the sender waits for every owed result before going on.
  task automatic test_random_frames(input logic [31:0] limit, input int count);
    int goal;
    wait_idle();
    set_limit(limit);
    goal = parsed_bytes + count;
    while (parsed_bytes < goal) begin
      random_frame();
      if ($urandom_range(0, 59) == 0) wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin : main_sequence
    int waited;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    calm           = 1'b0;
    parsed_bytes   = 0;
    mismatch_count = 0;
    clear_parse_state();
    payload_limit  = MaxPayloadReset;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_frame_headers();
    test_length_limit();
    test_random_frames(32'd12, 180);
    test_random_frames(32'hFFFF_FFFF, 180);
    test_random_frames($urandom_range(0, 40), 180);
    test_random_frames(MaxPayloadReset, 160);

    // Final stretch at full rate on both sides.
    calm = 1'b1;
    test_random_frames(MaxPayloadReset, 100);

    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 64'(expected_results.size()), 64'd0);
    repeat (10) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #10ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
